/* hdl/patg_pkg.sv */
`timescale 1ns / 1ps

package patg_pkg;

  localparam int DEFAULT_SLOTS = 5;
  localparam int KEY_W = 8;
  localparam int RND_W = 15;
  localparam int PER_W = 8;
  localparam int DIV_W = 7;
  localparam int BITCNT_W = 4;
  localparam int KEY_ON_BIT = 7;
  localparam int KEY_HIGH_BIT = 6;
  localparam logic [PER_W-1:0] NOISE_MAX_PERIOD = 8'd9;
  localparam logic [PER_W-1:0] VOLUME_RESET = 8'd255;

  localparam logic [1:0] CMD_KEY = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_STEP = 2'd2;
  localparam logic [1:0] CMD_TONE = 2'd3;

  typedef struct packed {
    logic [1:0] cmd;
    logic [KEY_W-1:0] key_byte;
    logic [RND_W-1:0] random_value;
  } in_word_t;

  typedef struct packed {
    logic [7:0] drive_level;
    logic [PER_W-1:0] active_period;
    logic [2:0] active_slot;
    logic [7:0] noise_period;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KEY_SCAN,
    ST_CLR_SCAN,
    ST_STEP_SCAN,
    ST_MOD_SEED,
    ST_MOD_ITER,
    ST_NOISE_ADD,
    ST_TONE,
    ST_FIN
  } state_t;

  function automatic logic [PER_W-1:0] period_rom(input logic [5:0] key);
    logic [PER_W-1:0] p;
    case (key)
      6'd0: p = 8'd254;   6'd1: p = 8'd239;   6'd2: p = 8'd226;   6'd3: p = 8'd213;
      6'd4: p = 8'd201;   6'd5: p = 8'd190;   6'd6: p = 8'd179;   6'd7: p = 8'd169;
      6'd8: p = 8'd160;   6'd9: p = 8'd151;   6'd10: p = 8'd142;  6'd11: p = 8'd134;
      6'd12: p = 8'd127;  6'd13: p = 8'd119;  6'd14: p = 8'd113;  6'd15: p = 8'd106;
      6'd16: p = 8'd100;  6'd17: p = 8'd95;   6'd18: p = 8'd89;   6'd19: p = 8'd84;
      6'd20: p = 8'd80;   6'd21: p = 8'd75;   6'd22: p = 8'd71;   6'd23: p = 8'd67;
      6'd24: p = 8'd63;   6'd25: p = 8'd59;   6'd26: p = 8'd56;   6'd27: p = 8'd53;
      6'd28: p = 8'd50;   6'd29: p = 8'd47;   6'd30: p = 8'd44;   6'd31: p = 8'd42;
      6'd32: p = 8'd40;   6'd33: p = 8'd37;   6'd34: p = 8'd35;   6'd35: p = 8'd33;
      6'd36: p = 8'd31;   6'd37: p = 8'd29;   6'd38: p = 8'd28;   6'd39: p = 8'd26;
      6'd40: p = 8'd25;   6'd41: p = 8'd23;   6'd42: p = 8'd22;   6'd43: p = 8'd21;
      6'd44: p = 8'd19;   6'd45: p = 8'd18;   6'd46: p = 8'd17;   6'd47: p = 8'd16;
      6'd48: p = 8'd15;   6'd49: p = 8'd14;   6'd50: p = 8'd14;   6'd51: p = 8'd13;
      6'd52: p = 8'd12;   6'd53: p = 8'd11;   6'd54: p = 8'd11;   6'd55: p = 8'd9;
      6'd56: p = 8'd8;    6'd57: p = 8'd7;    6'd58: p = 8'd6;    6'd59: p = 8'd5;
      6'd60: p = 8'd4;    6'd61: p = 8'd3;    6'd62: p = 8'd2;    6'd63: p = 8'd1;
      default: p = 8'd0;
    endcase
    return p;
  endfunction

endpackage

/* hdl/patg_slot_file.sv */
`timescale 1ns / 1ps

module patg_slot_file #(
  parameter int SLOTS = patg_pkg::DEFAULT_SLOTS,
  parameter int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           we,
  input  logic [SLOT_W-1:0]              waddr,
  input  logic [patg_pkg::PER_W-1:0]     wdata,
  input  logic [SLOT_W-1:0]              raddr,
  output logic [patg_pkg::PER_W-1:0]     rdata
);

  logic [patg_pkg::PER_W-1:0] slots [SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slots[i] <= '0;
      end
    end else if (we) begin
      slots[waddr] <= wdata;
    end
  end

  assign rdata = slots[raddr];

endmodule

/* hdl/polyphonic_arpeggio_tone_generator.sv */
`timescale 1ns / 1ps

// Channel  Signals                          Width  Direction
// in       in_valid, in_ready, in_data      25     into the block
// out      out_valid, out_ready, out_data   27     out of the block
// cfg      cfg_valid, cfg_ready, cfg_data   8      into the block
//
// A step tick searches the slots for the next active one, then runs the
// bit-serial modulo and the final add when the new period is 1 to 9.
// Reset empties all slots and sets the volume to 255.
// A finished word waits in the output register; a new word is accepted meanwhile.

module polyphonic_arpeggio_tone_generator #(
  parameter int SLOTS = patg_pkg::DEFAULT_SLOTS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  patg_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output patg_pkg::out_word_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_data
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  patg_pkg::state_t state, state_next;

  logic [SLOT_W-1:0] idx, idx_next;
  logic [SLOT_W-1:0] off_cnt, off_cnt_next;
  logic [patg_pkg::BITCNT_W-1:0] bit_cnt, bit_cnt_next;
  logic [patg_pkg::PER_W-1:0] period, period_next;
  logic [patg_pkg::DIV_W-1:0] div, div_next;
  logic [patg_pkg::PER_W-1:0] rem, rem_next;
  logic [patg_pkg::RND_W-1:0] rnd, rnd_next;
  logic key_on, key_on_next;
  logic [SLOT_W-1:0] cur_slot, cur_slot_next;
  logic [7:0] noise_len, noise_len_next;
  logic [7:0] tone_counter, tone_counter_next;
  logic [7:0] drive_reg, drive_reg_next;
  logic [7:0] volume;
  logic out_valid_next;
  patg_pkg::out_word_t out_data_next;

  logic slot_we;
  logic [SLOT_W-1:0] slot_waddr;
  logic [patg_pkg::PER_W-1:0] slot_wdata;
  logic [SLOT_W-1:0] slot_raddr;
  logic [patg_pkg::PER_W-1:0] slot_rdata;

  logic [patg_pkg::PER_W-1:0] trial;
  logic [7:0] tone_inc;

  patg_slot_file #(
    .SLOTS  (SLOTS),
    .SLOT_W (SLOT_W)
  ) u_slots (
    .clk   (clk),
    .rst   (rst),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      volume <= patg_pkg::VOLUME_RESET;
    end else if (cfg_valid) begin
      volume <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= patg_pkg::ST_IDLE;
      cur_slot <= '0;
      noise_len <= '0;
      tone_counter <= '0;
      drive_reg <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cur_slot <= cur_slot_next;
      noise_len <= noise_len_next;
      tone_counter <= tone_counter_next;
      drive_reg <= drive_reg_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    off_cnt <= off_cnt_next;
    bit_cnt <= bit_cnt_next;
    period <= period_next;
    div <= div_next;
    rem <= rem_next;
    rnd <= rnd_next;
    key_on <= key_on_next;
    out_data <= out_data_next;
  end

  always_comb begin
    trial = {rem[patg_pkg::DIV_W-1:0], rnd[patg_pkg::RND_W-1]};
    tone_inc = tone_counter + 8'd1;
  end

  always_comb begin
    state_next = state;
    idx_next = idx;
    off_cnt_next = off_cnt;
    bit_cnt_next = bit_cnt;
    period_next = period;
    div_next = div;
    rem_next = rem;
    rnd_next = rnd;
    key_on_next = key_on;
    cur_slot_next = cur_slot;
    noise_len_next = noise_len;
    tone_counter_next = tone_counter;
    drive_reg_next = drive_reg;
    out_valid_next = out_valid && !out_ready;
    out_data_next = out_data;
    in_ready = 1'b0;
    slot_we = 1'b0;
    slot_waddr = idx;
    slot_wdata = '0;
    slot_raddr = cur_slot;

    case (state)
      patg_pkg::ST_IDLE: begin
        in_ready = !rst;
        if (in_valid) begin
          idx_next = '0;
          rnd_next = in_data.random_value;
          key_on_next = in_data.key_byte[patg_pkg::KEY_ON_BIT];
          period_next = patg_pkg::period_rom(in_data.key_byte[5:0]);
          case (in_data.cmd)
            patg_pkg::CMD_KEY: begin
              if (in_data.key_byte[patg_pkg::KEY_HIGH_BIT]) begin
                state_next = patg_pkg::ST_FIN;
              end else begin
                state_next = patg_pkg::ST_KEY_SCAN;
              end
            end
            patg_pkg::CMD_CLEAR: state_next = patg_pkg::ST_CLR_SCAN;
            patg_pkg::CMD_STEP: begin
              idx_next = (cur_slot == LAST_SLOT) ? '0 : cur_slot + 1'b1;
              off_cnt_next = SLOT_W'(1);
              state_next = patg_pkg::ST_STEP_SCAN;
            end
            default: state_next = patg_pkg::ST_TONE;
          endcase
        end
      end

      patg_pkg::ST_KEY_SCAN: begin
        slot_raddr = idx;
        slot_wdata = key_on ? period : '0;
        if (key_on && slot_rdata == '0) begin
          slot_we = 1'b1;
          state_next = patg_pkg::ST_FIN;
        end else begin
          slot_we = !key_on && slot_rdata == period;
          if (idx == LAST_SLOT) begin
            state_next = patg_pkg::ST_FIN;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end

      patg_pkg::ST_CLR_SCAN: begin
        slot_we = 1'b1;
        if (idx == LAST_SLOT) begin
          state_next = patg_pkg::ST_FIN;
        end else begin
          idx_next = idx + 1'b1;
        end
      end

      patg_pkg::ST_STEP_SCAN: begin
        slot_raddr = idx;
        if (slot_rdata != '0) begin
          cur_slot_next = idx;
          state_next = patg_pkg::ST_MOD_SEED;
        end else if (off_cnt == LAST_SLOT) begin
          state_next = patg_pkg::ST_MOD_SEED;
        end else begin
          idx_next = (idx == LAST_SLOT) ? '0 : idx + 1'b1;
          off_cnt_next = off_cnt + 1'b1;
        end
      end

      patg_pkg::ST_MOD_SEED: begin
        period_next = slot_rdata;
        rem_next = '0;
        bit_cnt_next = '0;
        div_next = patg_pkg::DIV_W'(slot_rdata[3:0] * 7'd10);
        if (slot_rdata != '0 && slot_rdata <= patg_pkg::NOISE_MAX_PERIOD) begin
          state_next = patg_pkg::ST_MOD_ITER;
        end else begin
          noise_len_next = '0;
          state_next = patg_pkg::ST_FIN;
        end
      end

      patg_pkg::ST_MOD_ITER: begin
        rnd_next = {rnd[patg_pkg::RND_W-2:0], 1'b0};
        rem_next = (trial >= {1'b0, div}) ? trial - {1'b0, div} : trial;
        bit_cnt_next = bit_cnt + 1'b1;
        if (bit_cnt == patg_pkg::BITCNT_W'(patg_pkg::RND_W - 1)) begin
          state_next = patg_pkg::ST_NOISE_ADD;
        end
      end

      patg_pkg::ST_NOISE_ADD: begin
        noise_len_next = rem + 8'(period[3:0] * 8'd18);
        state_next = patg_pkg::ST_FIN;
      end

      patg_pkg::ST_TONE: begin
        if (noise_len == '0) begin
          if (tone_counter >= slot_rdata) begin
            tone_counter_next = '0;
            drive_reg_next = '0;
          end else begin
            tone_counter_next = tone_inc;
            drive_reg_next = (slot_rdata != '0) ? volume : '0;
          end
        end else begin
          if (tone_inc >= noise_len) begin
            tone_counter_next = '0;
            drive_reg_next = '0;
          end else begin
            tone_counter_next = tone_inc;
            drive_reg_next = volume;
          end
        end
        state_next = patg_pkg::ST_FIN;
      end

      patg_pkg::ST_FIN: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          out_data_next.drive_level = drive_reg;
          out_data_next.active_period = slot_rdata;
          out_data_next.active_slot = 3'(cur_slot);
          out_data_next.noise_period = noise_len;
          state_next = patg_pkg::ST_IDLE;
        end
      end

      default: state_next = patg_pkg::ST_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("block took a second word while busy");

  a_noise_range: assert property (@(posedge clk) disable iff (rst)
    noise_len != '0 |-> noise_len >= 8'd18 && noise_len <= 8'd251)
    else $error("noise period out of range");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    cur_slot <= LAST_SLOT)
    else $error("selected slot beyond the table");

  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    state == patg_pkg::ST_MOD_ITER |-> rem < {1'b0, div})
    else $error("modulo remainder not below divisor");
`endif

endmodule
